/* src/pdfs_pkg.sv */
// Shared types and constants for the PLL divider factor search unit.
package pdfs_pkg;

    localparam int RATE_W    = 32;
    localparam int PROD_W    = 40;
    localparam int BYTE_W    = 8;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PRE_DIVIDER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_DIVIDER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FIRST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SECOND  = 3'd5;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_TARGET_ZERO = 2'd1;
    localparam logic [1:0] STATUS_NO_FIT      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE_DIV,
        ST_QB_DIV,
        ST_Q0_DIV,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] target_rate;
        logic [31:0] ref_rate;
    } req_t;

    typedef struct packed {
        logic [31:0] chosen_rate;
        logic [7:0]  factor_n;
        logic        pre_index;
        logic [1:0]  post_index;
        logic [1:0]  status;
    } rsp_t;

endpackage

/* src/pll_divider_factor_search_unit.sv */
// PLL integer-N divider factor search: sequencer, shared divider and candidate scan.
//
// One request item takes a target and a parent rate and returns one item with the best
// multiplier and divider indices. The block takes one item at a time (req_stall is high
// from acceptance until the result is loaded into the output register); a waiting result
// does not block the next request. The search time is set by one shared restoring divider
// that retires one quotient bit per cycle over 40 bits (one division per pre divider, two per
// post divider) and by the scan that steps quotient and remainder by one multiplier per
// cycle. The scan stops at the first candidate above the target or at the multiplier limit,
// and the whole search at an exact match. A zero target goes straight to the finish state.
module pll_divider_factor_search_unit
    import pdfs_pkg::*;
#(
    parameter int PRE_CHOICES  = 2,
    parameter int POST_CHOICES = 4,
    parameter int MIN_FACTOR   = 11,
    parameter int FACTOR_BITS  = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int PRE_CAP  = (PRE_CHOICES < 2) ? PRE_CHOICES : 2;
    localparam int POST_CAP = (POST_CHOICES < 4) ? POST_CHOICES : 4;
    localparam int MAX_FAC  = (1 << FACTOR_BITS) - 1;
    localparam logic [BYTE_W-1:0] MIN_K = BYTE_W'(MIN_FACTOR);

    state_t state_reg, state_next;

    logic [15:0]           pre_div_reg;
    logic [31:0]           post_div_reg;
    logic [1:0]            pre_count_reg;
    logic [2:0]            post_count_reg;
    logic [BYTE_W-1:0]     limit_first_reg;
    logic [BYTE_W-1:0]     limit_second_reg;

    logic [RATE_W-1:0]     target_reg, target_next;
    logic [RATE_W-1:0]     parent_reg, parent_next;
    logic                  tz_reg, tz_next;
    logic [RATE_W-1:0]     base_reg, base_next;
    logic [RATE_W-1:0]     qb_reg, qb_next;
    logic [BYTE_W-1:0]     rb_reg, rb_next;
    logic [PROD_W-1:0]     q_reg, q_next;
    logic [BYTE_W-1:0]     r_reg, r_next;
    logic [BYTE_W-1:0]     k_reg, k_next;
    logic                  i_reg, i_next;
    logic [1:0]            j_reg, j_next;
    logic [RATE_W-1:0]     chosen_rate_reg, chosen_rate_next;
    logic [BYTE_W-1:0]     best_n_reg, best_n_next;
    logic                  best_pre_reg, best_pre_next;
    logic [1:0]            best_post_reg, best_post_next;
    logic [PROD_W-1:0]     div_dvd_reg, div_dvd_next;
    logic [BYTE_W-1:0]     div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_data_reg, rsp_data_next;

    logic [BYTE_W-1:0]     pre_byte, post_byte, divisor;
    logic [BYTE_W-1:0]     lim_sel, lim_eff;
    logic                  lim_skip, pre_last, post_last, k_last;
    logic                  div_done;
    logic [BYTE_W:0]       div_shift, div_diff;
    logic                  div_ge;
    logic [BYTE_W:0]       r_sum, r_diff;
    logic                  r_wrap;
    logic [BYTE_W-1:0]     r_step;
    logic [PROD_W-1:0]     q_step;
    logic [PROD_W-1:0]     base_mul;
    logic [PROD_W-1:0]     target_wide;
    logic                  scan_lt, scan_eq;
    logic                  rsp_free;

    // Divider bytes; a zero byte acts as one
    always_comb
    begin
        pre_byte  = i_reg ? pre_div_reg[15:8] : pre_div_reg[7:0];
        post_byte = post_div_reg[{j_reg, 3'b000} +: BYTE_W];
        if (pre_byte == '0)
        begin
            pre_byte = BYTE_W'(1);
        end
        if (post_byte == '0)
        begin
            post_byte = BYTE_W'(1);
        end
        divisor = (state_reg == ST_PRE_DIV) ? pre_byte : post_byte;
    end

    // Search bounds from the configuration
    always_comb
    begin
        int pc;
        int qc;
        pc = int'(pre_count_reg);
        qc = int'(post_count_reg);
        if (pc == 0)
        begin
            pc = 1;
        end
        if (pc > PRE_CAP)
        begin
            pc = PRE_CAP;
        end
        if (qc == 0)
        begin
            qc = 1;
        end
        if (qc > POST_CAP)
        begin
            qc = POST_CAP;
        end
        pre_last  = (i_reg == 1'(pc - 1));
        post_last = (j_reg == 2'(qc - 1));
        lim_sel   = i_reg ? limit_second_reg : limit_first_reg;
        lim_eff   = (int'(lim_sel) > MAX_FAC) ? BYTE_W'(MAX_FAC) : lim_sel;
        lim_skip  = (lim_eff < MIN_K);
        k_last    = (k_reg == lim_eff);
    end

    // Shared restoring divider step, one quotient bit per cycle
    assign div_done  = (div_cnt_reg == '0);
    assign div_shift = {div_rem_reg, div_dvd_reg[PROD_W-1]};
    assign div_diff  = div_shift - {1'b0, divisor};
    assign div_ge    = (div_shift >= {1'b0, divisor});

    // Candidate step: add base/post as quotient and remainder
    assign r_sum  = {1'b0, r_reg} + {1'b0, rb_reg};
    assign r_diff = r_sum - {1'b0, divisor};
    assign r_wrap = (r_sum >= {1'b0, divisor});
    assign r_step = r_wrap ? r_diff[BYTE_W-1:0] : r_sum[BYTE_W-1:0];
    assign q_step = q_reg + PROD_W'(qb_reg) + PROD_W'(r_wrap);

    assign base_mul    = PROD_W'(base_reg) * PROD_W'(MIN_K);
    assign target_wide = PROD_W'(target_reg);
    assign scan_lt     = (q_reg < target_wide);
    assign scan_eq     = (q_reg == target_wide);
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_data.target_rate == '0) ? ST_FINISH : ST_PRE_DIV;
                end
            end
            ST_PRE_DIV:
            begin
                if (div_done)
                begin
                    if (!lim_skip)
                    begin
                        state_next = ST_QB_DIV;
                    end
                    else if (pre_last)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_QB_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_Q0_DIV;
                end
            end
            ST_Q0_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_eq)
                begin
                    state_next = ST_FINISH;
                end
                else if (!(scan_lt && !k_last))
                begin
                    if (!post_last)
                    begin
                        state_next = ST_QB_DIV;
                    end
                    else if (!pre_last)
                    begin
                        state_next = ST_PRE_DIV;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates
    always_comb
    begin
        target_next      = target_reg;
        parent_next      = parent_reg;
        tz_next          = tz_reg;
        base_next        = base_reg;
        qb_next          = qb_reg;
        rb_next          = rb_reg;
        q_next           = q_reg;
        r_next           = r_reg;
        k_next           = k_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        chosen_rate_next = chosen_rate_reg;
        best_n_next      = best_n_reg;
        best_pre_next    = best_pre_reg;
        best_post_next   = best_post_reg;
        div_dvd_next     = div_dvd_reg;
        div_rem_next     = div_rem_reg;
        div_cnt_next     = div_cnt_reg;
        rsp_data_next    = rsp_data_reg;
        rsp_valid_next   = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (!div_done)
        begin
            div_dvd_next = {div_dvd_reg[PROD_W-2:0], div_ge};
            div_rem_next = div_ge ? div_diff[BYTE_W-1:0] : div_shift[BYTE_W-1:0];
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    target_next      = req_data.target_rate;
                    parent_next      = req_data.ref_rate;
                    tz_next          = (req_data.target_rate == '0);
                    chosen_rate_next = '0;
                    best_n_next      = BYTE_W'(1);
                    best_pre_next    = 1'b0;
                    best_post_next   = '0;
                    i_next           = 1'b0;
                    j_next           = '0;
                    div_dvd_next     = PROD_W'(req_data.ref_rate);
                    div_rem_next     = '0;
                    // leave the divider idle for a zero target
                    div_cnt_next     = (req_data.target_rate == '0) ? '0 : DIV_CNT_W'(PROD_W);
                end
            end
            ST_PRE_DIV:
            begin
                if (div_done)
                begin
                    base_next = div_dvd_reg[RATE_W-1:0];
                    j_next    = '0;
                    if (!lim_skip)
                    begin
                        div_dvd_next = PROD_W'(div_dvd_reg[RATE_W-1:0]);
                        div_rem_next = '0;
                        div_cnt_next = DIV_CNT_W'(PROD_W);
                    end
                    else if (!pre_last)
                    begin
                        // skip this pre divider, no multiplier fits
                        i_next       = 1'b1;
                        div_dvd_next = PROD_W'(parent_reg);
                        div_rem_next = '0;
                        div_cnt_next = DIV_CNT_W'(PROD_W);
                    end
                end
            end
            ST_QB_DIV:
            begin
                if (div_done)
                begin
                    qb_next      = div_dvd_reg[RATE_W-1:0];
                    rb_next      = div_rem_reg;
                    div_dvd_next = base_mul;
                    div_rem_next = '0;
                    div_cnt_next = DIV_CNT_W'(PROD_W);
                end
            end
            ST_Q0_DIV:
            begin
                if (div_done)
                begin
                    q_next = div_dvd_reg;
                    r_next = div_rem_reg;
                    k_next = MIN_K;
                end
            end
            ST_SCAN:
            begin
                if ((scan_lt && (q_reg[RATE_W-1:0] > chosen_rate_reg)) || scan_eq)
                begin
                    chosen_rate_next = q_reg[RATE_W-1:0];
                    best_n_next      = k_reg;
                    best_pre_next    = i_reg;
                    best_post_next   = j_reg;
                end
                if (scan_lt && !k_last)
                begin
                    k_next = k_reg + BYTE_W'(1);
                    q_next = q_step;
                    r_next = r_step;
                end
                else if (!scan_eq)
                begin
                    // end of this multiplier run: advance post, then pre
                    if (!post_last)
                    begin
                        j_next       = j_reg + 2'd1;
                        div_dvd_next = PROD_W'(base_reg);
                        div_rem_next = '0;
                        div_cnt_next = DIV_CNT_W'(PROD_W);
                    end
                    else if (!pre_last)
                    begin
                        i_next       = 1'b1;
                        j_next       = '0;
                        div_dvd_next = PROD_W'(parent_reg);
                        div_rem_next = '0;
                        div_cnt_next = DIV_CNT_W'(PROD_W);
                    end
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (tz_reg || (chosen_rate_reg == '0))
                    begin
                        rsp_data_next.chosen_rate = '0;
                        rsp_data_next.factor_n    = BYTE_W'(1);
                        rsp_data_next.pre_index   = 1'b0;
                        rsp_data_next.post_index  = '0;
                        rsp_data_next.status      = tz_reg ? STATUS_TARGET_ZERO : STATUS_NO_FIT;
                    end
                    else
                    begin
                        rsp_data_next.chosen_rate = chosen_rate_reg;
                        rsp_data_next.factor_n    = best_n_reg;
                        rsp_data_next.pre_index   = best_pre_reg;
                        rsp_data_next.post_index  = best_post_reg;
                        rsp_data_next.status      = STATUS_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pre_div_reg      <= 16'h0201;
            post_div_reg     <= 32'h04030201;
            pre_count_reg    <= 2'd2;
            post_count_reg   <= 3'd4;
            limit_first_reg  <= 8'd50;
            limit_second_reg <= 8'd100;
            div_cnt_reg      <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PRE_DIVIDER:  pre_div_reg      <= cfg_data[15:0];
                    CFG_POST_DIVIDER: post_div_reg     <= cfg_data;
                    CFG_PRE_COUNT:    pre_count_reg    <= cfg_data[1:0];
                    CFG_POST_COUNT:   post_count_reg   <= cfg_data[2:0];
                    CFG_LIMIT_FIRST:  limit_first_reg  <= cfg_data[7:0];
                    CFG_LIMIT_SECOND: limit_second_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg      <= target_next;
        parent_reg      <= parent_next;
        tz_reg          <= tz_next;
        base_reg        <= base_next;
        qb_reg          <= qb_next;
        rb_reg          <= rb_next;
        q_reg           <= q_next;
        r_reg           <= r_next;
        k_reg           <= k_next;
        i_reg           <= i_next;
        j_reg           <= j_next;
        chosen_rate_reg <= chosen_rate_next;
        best_n_reg      <= best_n_next;
        best_pre_reg    <= best_pre_next;
        best_post_reg   <= best_post_next;
        div_dvd_reg     <= div_dvd_next;
        div_rem_reg     <= div_rem_next;
        rsp_data_reg    <= rsp_data_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign cfg_ready = 1'b1;

    a_div_only_in_div_states: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |->
            (state_reg == ST_PRE_DIV || state_reg == ST_QB_DIV || state_reg == ST_Q0_DIV))
        else $error("divider running outside a divide state");

    a_scan_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (r_reg < divisor))
        else $error("scan remainder not below post divider");

    a_scan_best_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (chosen_rate_reg < target_reg))
        else $error("best candidate reached target while still scanning");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status != STATUS_OK) |->
            (rsp_data.chosen_rate == '0 && rsp_data.factor_n == BYTE_W'(1)))
        else $error("error item carries a rate or multiplier");

endmodule

/* test/pll_factor_checker.sv */
// Checker for the PLL divider factor search unit: tracks registers, predicts and compares.
module pll_factor_checker
    import pdfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  req_t                 req_data,
    input  logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  rsp_t                 rsp_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   mismatches,
    output int                   pending
);

    localparam int NUM_PRE      = 2;
    localparam int NUM_POST     = 4;
    localparam int FIRST_FACTOR = 11;
    localparam int TOP_FACTOR   = 255;

    logic [15:0] pre_div_sh;
    logic [31:0] post_div_sh;
    logic [1:0]  pre_cnt_sh;
    logic [2:0]  post_cnt_sh;
    logic [7:0]  lim_first_sh;
    logic [7:0]  lim_second_sh;

    rsp_t expected_q[$];
    rsp_t oldest;
    int   errs;

    // A zero divider byte acts as one.
    function automatic logic [7:0] divider_byte(logic [31:0] vals, int idx);
        logic [7:0] d;
        d = vals[idx*8 +: 8];
        return (d == 8'd0) ? 8'd1 : d;
    endfunction

    function automatic rsp_t search_factors(req_t req);
        rsp_t        res;
        logic [63:0] base;
        logic [63:0] cand;
        logic [63:0] best;
        logic [7:0]  post_d;
        int          pre_n;
        int          post_n;
        int          lim;
        int          i;
        int          j;
        int          k;
        bit          hit;
        best           = '0;
        hit            = 1'b0;
        res.factor_n   = 8'd1;
        res.pre_index  = 1'b0;
        res.post_index = 2'd0;
        pre_n  = (pre_cnt_sh == 2'd0) ? 1 : int'(pre_cnt_sh);
        post_n = (post_cnt_sh == 3'd0) ? 1 : int'(post_cnt_sh);
        if (pre_n > NUM_PRE)
            pre_n = NUM_PRE;
        if (post_n > NUM_POST)
            post_n = NUM_POST;
        if (req.target_rate == 32'd0)
            res.status = STATUS_TARGET_ZERO;
        else
        begin
            for (i = 0; i < pre_n && !hit; i++)
            begin
                base = 64'(req.ref_rate) / 64'(divider_byte({16'h0, pre_div_sh}, i));
                lim  = (i == 0) ? int'(lim_first_sh) : int'(lim_second_sh);
                if (lim > TOP_FACTOR)
                    lim = TOP_FACTOR;
                for (j = 0; j < post_n && !hit; j++)
                begin
                    post_d = divider_byte(post_div_sh, j);
                    for (k = FIRST_FACTOR; k <= lim; k++)
                    begin
                        cand = (base * 64'(k)) / 64'(post_d);
                        if (cand < 64'(req.target_rate))
                        begin
                            // keep the first of equal candidates
                            if (best < cand)
                            begin
                                best           = cand;
                                res.factor_n   = 8'(k);
                                res.pre_index  = 1'(i);
                                res.post_index = 2'(j);
                            end
                        end
                        else
                        begin
                            if (cand == 64'(req.target_rate))
                            begin
                                best           = cand;
                                res.factor_n   = 8'(k);
                                res.pre_index  = 1'(i);
                                res.post_index = 2'(j);
                                hit            = 1'b1;
                            end
                            break;
                        end
                    end
                end
            end
            res.status = (best == 64'd0) ? STATUS_NO_FIT : STATUS_OK;
        end
        if (res.status != STATUS_OK)
        begin
            best           = '0;
            res.factor_n   = 8'd1;
            res.pre_index  = 1'b0;
            res.post_index = 2'd0;
        end
        res.chosen_rate = best[31:0];
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_div_sh    <= 16'h0201;
            post_div_sh   <= 32'h0403_0201;
            pre_cnt_sh    <= 2'd2;
            post_cnt_sh   <= 3'd4;
            lim_first_sh  <= 8'd50;
            lim_second_sh <= 8'd100;
            expected_q.delete();
            errs = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PRE_DIVIDER:  pre_div_sh    <= cfg_data[15:0];
                    CFG_POST_DIVIDER: post_div_sh   <= cfg_data;
                    CFG_PRE_COUNT:    pre_cnt_sh    <= cfg_data[1:0];
                    CFG_POST_COUNT:   post_cnt_sh   <= cfg_data[2:0];
                    CFG_LIMIT_FIRST:  lim_first_sh  <= cfg_data[7:0];
                    CFG_LIMIT_SECOND: lim_second_sh <= cfg_data[7:0];
                    default: ;
                endcase
            end
            // retire the result before queuing a new item
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result item with none expected, expected none, actual %0h",
                             $time, rsp_data);
                    errs++;
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    check_field("chosen_rate", oldest.chosen_rate, rsp_data.chosen_rate);
                    check_field("factor_n", 32'(oldest.factor_n), 32'(rsp_data.factor_n));
                    check_field("pre_index", 32'(oldest.pre_index), 32'(rsp_data.pre_index));
                    check_field("post_index", 32'(oldest.post_index), 32'(rsp_data.post_index));
                    check_field("status", 32'(oldest.status), 32'(rsp_data.status));
                end
            end
            if (req_valid && !req_stall)
                expected_q.push_back(search_factors(req_data));
            pending    <= expected_q.size();
            mismatches <= errs;
        end
    end

endmodule

/* test/testbench.sv */
// Top of the testbench for the PLL divider factor search unit: stimulus and verdict.
module testbench;
    import pdfs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int LOWEST_FACTOR = 11;
    localparam int PHASE_ITEMS   = 29;
    localparam int HOLD_ITEMS    = 6;
    localparam int HOLD_CYCLES   = 6000;
    localparam int DRAIN_CYCLES  = 64;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    int mismatches;
    int pending;
    int idle_pct;
    int stall_pct;
    int hold_token;

    // register values as last written, used to aim targets at reachable rates
    logic [15:0] pre_div_now;
    logic [31:0] post_div_now;
    logic [1:0]  pre_cnt_now;
    logic [2:0]  post_cnt_now;
    logic [7:0]  lim_now [2];

    pll_divider_factor_search_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pll_factor_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    initial
    begin
        #60_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, rare long bursts, and a long hold-off on request.
    initial
    begin
        int hold_seen;
        int burst;
        hold_seen = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                rsp_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall_pct > 0 && $urandom_range(999) == 0)
            begin
                burst     = $urandom_range(3000);
                rsp_stall = 1'b1;
                repeat (burst) @(negedge clk);
            end
            else
                rsp_stall = ($urandom_range(99) < stall_pct);
        end
    end

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            CFG_PRE_DIVIDER:  pre_div_now  = value[15:0];
            CFG_POST_DIVIDER: post_div_now = value;
            CFG_PRE_COUNT:    pre_cnt_now  = value[1:0];
            CFG_POST_COUNT:   post_cnt_now = value[2:0];
            CFG_LIMIT_FIRST:  lim_now[0]   = value[7:0];
            CFG_LIMIT_SECOND: lim_now[1]   = value[7:0];
            default: ;
        endcase
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic wait_all_results();
        @(negedge clk);
        req_valid = 1'b0;
        wait (pending == 0);
    endtask

    task automatic send_rates(logic [31:0] target, logic [31:0] parent);
        int gap;
        gap = 0;
        @(negedge clk);
        req_valid = 1'b1;
        req_data  = {target, parent};
        do @(posedge clk); while (req_stall);
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (idle_pct > 0 && $urandom_range(15) == 0)
            gap += $urandom_range(1500);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random_items(int count);
        logic [31:0] parent;
        logic [31:0] target;
        logic [63:0] aim;
        logic [7:0]  pd;
        logic [7:0]  qd;
        int          mode;
        int          side;
        int          slot;
        int          slot_max;
        int          lim;
        int          k;
        repeat (count)
        begin
            mode     = $urandom_range(9);
            parent   = $urandom >> $urandom_range(31);
            side     = (pre_cnt_now >= 2'd2) ? $urandom_range(1) : 0;
            slot_max = (post_cnt_now == 3'd0) ? 1 : int'(post_cnt_now);
            if (slot_max > 4)
                slot_max = 4;
            slot = $urandom_range(slot_max - 1);
            pd   = pre_div_now[side*8 +: 8];
            qd   = post_div_now[slot*8 +: 8];
            if (pd == 8'd0)
                pd = 8'd1;
            if (qd == 8'd0)
                qd = 8'd1;
            lim = int'(lim_now[side]);
            k   = (lim > LOWEST_FACTOR) ? $urandom_range(lim, LOWEST_FACTOR) : LOWEST_FACTOR;
            aim = ((64'(parent) / 64'(pd)) * 64'(k)) / 64'(qd);
            case (mode)
                0: target = '0;
                1, 2:
                begin
                    target = $urandom;
                    parent = $urandom;
                end
                3, 4, 5: target = aim[31:0];
                default: target = aim[31:0] + 32'($urandom_range(2000)) - 32'd1000;
            endcase
            send_rates(target, parent);
        end
    endtask

    initial
    begin
        int ph;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_PRE_DIVIDER;
        cfg_data     = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_token   = 0;
        pre_div_now  = 16'h0201;
        post_div_now = 32'h0403_0201;
        pre_cnt_now  = 2'd2;
        post_cnt_now = 3'd4;
        lim_now[0]   = 8'd50;
        lim_now[1]   = 8'd100;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: zero target, zero parent, exact hits, nothing fits, extremes
        send_rates(32'd0, $urandom);
        send_rates(32'd0, 32'd0);
        send_rates(32'd264_000_000, 32'd24_000_000);
        send_rates('1, '1);
        send_rates('1, 32'd1);
        send_rates(32'd1, 32'd1);
        send_rates(32'd100, 32'd7);
        send_rates(32'd12_000_000, 32'd1_000_000);
        // exact only with the second pre divider
        send_rates(32'd99_000_000, 32'd2_000_000);
        send_rates($urandom, $urandom);

        wait_all_results();
        put_reg(CFG_PRE_DIVIDER, 32'd0);
        put_reg(CFG_POST_DIVIDER, 32'd0);
        send_rates(32'd300_000_000, 32'd10_000_000);
        send_rates(32'h8000_0000, 32'h0100_0000);

        wait_all_results();
        put_reg(CFG_PRE_COUNT, 32'd0);
        put_reg(CFG_POST_COUNT, 32'd0);
        send_rates(32'd77_000_000, 32'd3_000_000);

        wait_all_results();
        put_reg(CFG_PRE_COUNT, 32'd3);
        put_reg(CFG_POST_COUNT, 32'd7);
        put_reg(CFG_PRE_DIVIDER, 32'h0000_0503);
        put_reg(CFG_POST_DIVIDER, 32'h0807_0605);
        send_rates($urandom, 32'd5_000_000);

        // limits below the lowest multiplier try nothing
        wait_all_results();
        put_reg(CFG_LIMIT_FIRST, 32'd10);
        put_reg(CFG_LIMIT_SECOND, 32'd0);
        send_rates(32'd50_000_000, 32'd1_000_000);

        wait_all_results();
        put_reg(CFG_LIMIT_FIRST, 32'd11);
        put_reg(CFG_LIMIT_SECOND, 32'd255);
        send_rates('1, 32'h00FF_FFFF);
        send_rates(32'd11_000_000, 32'd3_000_000);

        // writes to unused indexes must leave the settings alone
        wait_all_results();
        put_reg(CFG_SPARE_LO, $urandom);
        put_reg(CFG_SPARE_HI, '1);
        send_rates(32'd33_000_000, 32'd9_000_000);

        for (ph = 0; ph < 4; ph++)
        begin
            wait_all_results();
            if (ph == 3)
            begin
                put_reg(CFG_PRE_DIVIDER, 32'h0000_FFFF);
                put_reg(CFG_POST_DIVIDER, '1);
                put_reg(CFG_PRE_COUNT, 32'd3);
                put_reg(CFG_POST_COUNT, 32'd7);
                put_reg(CFG_LIMIT_FIRST, 32'd255);
                put_reg(CFG_LIMIT_SECOND, 32'd255);
            end
            else
            begin
                put_reg(CFG_PRE_DIVIDER, $urandom);
                put_reg(CFG_POST_DIVIDER, $urandom);
                put_reg(CFG_PRE_COUNT, $urandom);
                put_reg(CFG_POST_COUNT, $urandom);
                put_reg(CFG_LIMIT_FIRST, $urandom);
                put_reg(CFG_LIMIT_SECOND, $urandom);
            end
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 71;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 71;
                end
                default:
                begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            send_random_items(PHASE_ITEMS);
            if (ph == 0)
            begin
                // hold the result side so the block backs up and stalls requests
                hold_token++;
                send_random_items(HOLD_ITEMS);
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
